### src/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types and constants for the difficulty target check block.
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int WORD_W    = 64;
    localparam int TARGET_W  = 256;
    localparam int BIT_CNT_W = 8;
    localparam int ADDR_W    = 4;

    // 0xFFFF0000 * 1e9, placed at bit 192 of the dividend
    localparam logic [WORD_W-1:0] NUM_DIVIDEND  = 64'd4294901760 * 64'd1000000000;
    localparam logic [WORD_W-1:0] RESET_DIVISOR = 64'd1000000000;

    localparam logic REG_SCALED_DIFFICULTY = 1'b0;

    typedef enum logic [1:0] {
        IDX_WORD0 = 2'd0,
        IDX_WORD1 = 2'd1,
        IDX_WORD2 = 2'd2,
        IDX_WORD3 = 2'd3
    } t_word_idx;

    typedef enum logic [1:0] {
        CMP_EQUAL   = 2'd0,
        CMP_LESS    = 2'd1,
        CMP_GREATER = 2'd2
    } t_cmp;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DIV  = 1'b1
    } t_state;

    typedef struct packed {
        logic div_load;
        logic div_step;
        logic word_take;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic last_word;
    } t_dp_sts;

endpackage

### src/dtc_datapath.sv
// ----------------------------------------------------------------------------
// dtc_datapath
// Bit-serial restoring divider for the share target, target storage and the
// word-by-word hash compare with its result register.
// ----------------------------------------------------------------------------
module dtc_datapath
    import dtc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [WORD_W-1:0]   i_divisor,
    input  logic [WORD_W-1:0]   i_hash_word,
    input  logic [1:0]          i_word_index,
    output logic                o_meets_target
);

    logic [WORD_W-1:0]    r_div;
    logic [WORD_W-1:0]    r_rem;
    logic [TARGET_W-1:0]  r_quo;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    t_cmp                 r_status;
    logic                 r_meets;

    logic                 num_bit;
    logic [WORD_W-1:0]    shifted;
    logic                 q_bit;
    logic [WORD_W-1:0]    target_word;
    t_cmp                 cur_status;
    t_cmp                 n_status;

    // dividend is nonzero only in its top word
    assign num_bit = (r_bit_cnt[BIT_CNT_W-1:BIT_CNT_W-2] == 2'b11) ?
                     NUM_DIVIDEND[r_bit_cnt[5:0]] : 1'b0;
    assign shifted = {r_rem[WORD_W-2:0], num_bit};
    assign q_bit   = r_rem[WORD_W-1] | ({1'b0, shifted} >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_bit_cnt <= '1;
        end else if (i_cmd.div_step) begin
            r_bit_cnt <= r_bit_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div <= (i_divisor == '0) ? WORD_W'(1) : i_divisor;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? (shifted - r_div) : shifted;
            r_quo <= {r_quo[TARGET_W-2:0], q_bit};
        end
    end

    always_comb begin
        case (t_word_idx'(i_word_index))
            IDX_WORD0: target_word = r_quo[255:192];
            IDX_WORD1: target_word = r_quo[191:128];
            IDX_WORD2: target_word = r_quo[127:64];
            IDX_WORD3: target_word = r_quo[63:0];
            default:   target_word = r_quo[63:0];
        endcase
    end

    always_comb begin
        cur_status = (i_word_index == IDX_WORD0) ? CMP_EQUAL : r_status;
        n_status   = cur_status;
        if (cur_status == CMP_EQUAL) begin
            if (i_hash_word < target_word) begin
                n_status = CMP_LESS;
            end else if (i_hash_word > target_word) begin
                n_status = CMP_GREATER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= CMP_EQUAL;
        end else if (i_cmd.word_take) begin
            r_status <= (i_word_index == IDX_WORD3) ? CMP_EQUAL : n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.word_take && (i_word_index == IDX_WORD3)) begin
            r_meets <= (n_status != CMP_GREATER);
        end
    end

    assign o_sts.div_last  = (r_bit_cnt == '0);
    assign o_sts.last_word = (i_word_index == IDX_WORD3);
    assign o_meets_target  = r_meets;

endmodule

### src/dtc_ctrl.sv
// ----------------------------------------------------------------------------
// dtc_ctrl
// Sequencer: starts a target rebuild after reset or a divisor write, runs
// the divider, then admits hash words and tracks the result valid flag.
// ----------------------------------------------------------------------------
module dtc_ctrl
    import dtc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_write,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;
    logic   r_stale;
    logic   n_stale;
    logic   r_out_valid;
    logic   in_ready;
    logic   take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stale     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stale <= n_stale | i_cfg_write;
            if (take && i_sts.last_word) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_stale  = r_stale;
        in_ready = 1'b0;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (r_stale) begin
                    o_cmd.div_load = 1'b1;
                    n_stale        = 1'b0;
                    n_state        = S_DIV;
                end else begin
                    in_ready = !r_out_valid || i_ready;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.word_take = in_ready && i_valid;
    end

    assign take    = in_ready && i_valid;
    assign o_ready = in_ready;
    assign o_valid = r_out_valid;

endmodule

### src/difficulty_target_check.sv
// ----------------------------------------------------------------------------
// difficulty_target_check
// Share target test for a 256-bit hash against a target derived from the
// configured scaled difficulty.
// ----------------------------------------------------------------------------
// After reset or a write of scaled_difficulty the block rebuilds the target
// floor(0xFFFF * 2^208 * 1e9 / divisor) with a one-bit-per-cycle restoring
// divider and holds o_ready low meanwhile; a divisor of zero acts as one.
// Once the target is ready a hash word is taken every cycle, most significant
// word first, and one transfer on the output follows each word with index 3
// in the next cycle, reporting hash <= target. While a result waits, the
// input is held off unless that result is taken in the same cycle. The
// divisor sits at APB address 0, aliased across addresses 0 to 7.
// ----------------------------------------------------------------------------
module difficulty_target_check
    import dtc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [WORD_W-1:0]   pwdata,
    output logic [WORD_W-1:0]   prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [WORD_W-1:0]   i_hash_word,
    input  logic [1:0]          i_word_index,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_meets_target
);

    logic [WORD_W-1:0] r_scaled_difficulty;
    logic              cfg_write;
    t_dp_cmd           dp_cmd;
    t_dp_sts           dp_sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[ADDR_W-1] == REG_SCALED_DIFFICULTY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaled_difficulty <= RESET_DIVISOR;
        end else if (cfg_write) begin
            r_scaled_difficulty <= pwdata;
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_SCALED_DIFFICULTY) ?
                    r_scaled_difficulty : '0;

    dtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (cfg_write),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    dtc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_divisor      (r_scaled_difficulty),
        .i_hash_word    (i_hash_word),
        .i_word_index   (i_word_index),
        .o_meets_target (o_meets_target)
    );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the share target test of difficulty_target_check. Hash words are
// streamed in against targets built from a range of difficulty settings, and
// each verdict is compared with a local model of the target division and of
// the word by word comparison. Both handshake sides idle at random. The
// output is also held off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
    import dtc_pkg::*;
();

    localparam logic [63:0]       SHARE_NUM         = 64'd4294901760 * 64'd1000000000;
    localparam logic [63:0]       RESET_DIFFICULTY  = 64'd1000000000;
    localparam logic [ADDR_W-1:0] DIFF_ADDR         = ADDR_W'(8 * REG_SCALED_DIFFICULTY);
    localparam int                SETTLE_CYCLES     = 8;
    localparam int                STALL_CYCLES      = 200;
    localparam int                WATCHDOG_LIMIT    = 2000;
    localparam int                PHASES            = 12;
    localparam int                WORDS_PER_PHASE   = 120;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [WORD_W-1:0]   pwdata       = '0;
    logic [WORD_W-1:0]   prdata;
    logic                pready;
    logic                i_valid      = 1'b0;
    logic                o_ready;
    logic [WORD_W-1:0]   i_hash_word  = '0;
    logic [1:0]          i_word_index = '0;
    logic                o_valid;
    logic                i_ready      = 1'b0;
    logic                o_meets_target;

    logic                calm         = 1'b0;
    int                  hold_req     = 0;
    int                  hold_ack     = 0;
    int                  hold_left    = 0;
    int                  quiet_cycles = 0;
    int                  mismatches   = 0;
    int                  words_sent   = 0;
    logic [255:0]        cur_target;

    logic [63:0]         pr_divisor;
    logic [255:0]        pr_target;
    t_cmp                pr_cmp;
    logic                pr_stale;
    bit                  pending_verdicts[$];

    difficulty_target_check DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_hash_word    (i_hash_word),
        .i_word_index   (i_word_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_meets_target (o_meets_target)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [255:0] share_target(logic [63:0] d);
        logic [255:0] dividend;
        logic [255:0] divisor;
        dividend = {SHARE_NUM, 192'd0};
        divisor  = {192'd0, (d == 64'd0) ? 64'd1 : d};
        return dividend / divisor;
    endfunction

    task automatic predict_hash_word(logic [63:0] w, t_word_idx idx);
        logic [63:0] t;
        if (pr_stale) begin
            pr_target = share_target(pr_divisor);
            pr_stale  = 1'b0;
        end
        if (idx == IDX_WORD0)
            pr_cmp = CMP_EQUAL;
        t = pr_target[(3 - idx) * 64 +: 64];
        if (pr_cmp == CMP_EQUAL) begin
            if (w < t)
                pr_cmp = CMP_LESS;
            else if (w > t)
                pr_cmp = CMP_GREATER;
        end
        if (idx == IDX_WORD3) begin
            pending_verdicts = {pending_verdicts, bit'(pr_cmp != CMP_GREATER)};
            pr_cmp = CMP_EQUAL;
        end
    endtask

    // transfer monitor: prediction, result check, watchdog
    always @(posedge i_clk) begin : monitor
        bit exp_meets;
        bit busy;
        if (i_rst_n) begin
            busy = 1'b0;
            if (psel && penable && pwrite && pready) begin
                busy = 1'b1;
                if (paddr == DIFF_ADDR) begin
                    pr_divisor = pwdata;
                    pr_stale   = 1'b1;
                end
            end
            if (i_valid && o_ready) begin
                busy = 1'b1;
                predict_hash_word(i_hash_word, t_word_idx'(i_word_index));
            end
            if (o_valid && i_ready) begin
                busy = 1'b1;
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: meets_target unexpected, expected none, actual %0b",
                             $time, o_meets_target);
                    mismatches++;
                end else begin
                    exp_meets = pending_verdicts.pop_front();
                    if (o_meets_target !== exp_meets) begin
                        $display("%0t: meets_target mismatch, expected %0b, actual %0b",
                                 $time, exp_meets, o_meets_target);
                        mismatches++;
                    end
                end
            end
            if (busy) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side: random stalls, calm stretches, long hold on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= STALL_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 16);
        end
    end

    task automatic send_word(logic [63:0] w, t_word_idx idx);
        if (!calm) begin
            while ($urandom_range(99) < 16) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid      <= 1'b1;
        i_hash_word  <= w;
        i_word_index <= idx;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_difficulty(logic [63:0] v);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIFF_ADDR;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== v) begin
            $display("%0t: scaled_difficulty readback, expected %0h, actual %0h",
                     $time, v, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_target = share_target(v);
    endtask

    task automatic send_target_hash();
        for (int k = 0; k < 4; k++)
            send_word(cur_target[(3 - k) * 64 +: 64], t_word_idx'(k));
    endtask

    function automatic logic [63:0] pick_word(logic [63:0] t);
        case ($urandom_range(9))
            0, 1, 2, 3: return t;
            4:          return t + 64'd1;
            5:          return t - 64'd1;
            6:          return '0;
            7:          return '1;
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random_hash();
        t_word_idx idx;
        if ($urandom_range(99) < 85) begin
            for (int k = 0; k < 4; k++)
                send_word(pick_word(cur_target[(3 - k) * 64 +: 64]), t_word_idx'(k));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                idx = t_word_idx'($urandom_range(3));
                send_word(pick_word(cur_target[(3 - idx) * 64 +: 64]), idx);
            end
        end
    endtask

    task automatic test_reset_target();
        logic [63:0] tw [4];
        for (int k = 0; k < 4; k++)
            tw[k] = cur_target[(3 - k) * 64 +: 64];
        send_target_hash();
        // first unequal word decides: less on top, all ones below
        send_word('0, IDX_WORD0);
        send_word('1, IDX_WORD1);
        send_word('1, IDX_WORD2);
        send_word('1, IDX_WORD3);
        // out of order, greater top word then last word
        send_word('1, IDX_WORD0);
        send_word('0, IDX_WORD3);
        // restart on word zero drops the earlier less
        send_word('0, IDX_WORD0);
        send_word(tw[0], IDX_WORD0);
        send_word(tw[1], IDX_WORD1);
        send_word(tw[2], IDX_WORD2);
        send_word(tw[3] + 64'd1, IDX_WORD3);
        send_word(tw[3], IDX_WORD3);
    endtask

    task automatic test_divisor_extremes();
        set_difficulty('0);
        send_target_hash();
        set_difficulty(64'd1);
        for (int k = 0; k < 4; k++)
            send_word('1, t_word_idx'(k));
        set_difficulty('1);
        send_target_hash();
    endtask

    task automatic test_output_stall();
        set_difficulty(RESET_DIFFICULTY);
        calm     <= 1'b1;
        hold_req <= hold_req + 1;
        repeat (40) send_random_hash();
        wait_drained();
        calm <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_random_hashes();
        logic [63:0] d;
        int          stop_at;
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(5))
                0:       d = {$urandom, $urandom};
                1:       d = 64'($urandom_range(1, 1000));
                2:       d = RESET_DIFFICULTY * 64'($urandom_range(1, 1000000));
                3:       d = {32'd0, $urandom};
                4:       d = $urandom_range(1) ? '1 : '0;
                default: d = RESET_DIFFICULTY;
            endcase
            set_difficulty(d);
            calm <= (ph == 1);
            stop_at = words_sent + WORDS_PER_PHASE;
            while (words_sent < stop_at)
                send_random_hash();
        end
        wait_drained();
        calm <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        pr_divisor = RESET_DIFFICULTY;
        pr_target  = share_target(RESET_DIFFICULTY);
        pr_cmp     = CMP_EQUAL;
        pr_stale   = 1'b0;
        cur_target = pr_target;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_target();
        test_divisor_extremes();
        test_output_stall();
        test_random_hashes();
        wait_drained();
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
src/dtc_pkg.sv
src/dtc_datapath.sv
src/dtc_ctrl.sv
src/difficulty_target_check.sv
tb/testbench.sv
